FILE: rtl/core/rpb_pkg.sv
// Shared types and constants for the RGB pixel blend unit.
package rpb_pkg;

    localparam int CHAN_W  = 8;
    localparam int MODE_W  = 3;
    localparam int PIXEL_W = 3 * CHAN_W;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

    localparam logic [MODE_W-1:0] MODE_BLACK    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LERP     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ADD      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SUBTRACT = 3'd3;
    localparam logic [MODE_W-1:0] MODE_MULTIPLY = 3'd4;
    localparam logic [MODE_W-1:0] MODE_DODGE    = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SCREEN   = 3'd6;
    // Unused code; blends to black like MODE_BLACK.
    localparam logic [MODE_W-1:0] MODE_SPARE    = 3'd7;

    // Pipeline control handed from the control block to the channel lanes.
    typedef struct packed {
        logic              load1;
        logic              load2;
        logic              load3;
        logic              valid2;
        logic [MODE_W-1:0] mode2;
        logic              in_stall;
        logic              out_valid;
    } ctrl_t;

endpackage

FILE: rtl/core/rpb_pipe_ctrl.sv
// Valid bits, stage load enables and mode register for the blend pipeline.
module rpb_pipe_ctrl
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       out_stall,
    input  logic                       cfg_valid,
    input  logic [rpb_pkg::MODE_W-1:0] cfg_data,
    output rpb_pkg::ctrl_t             ctrl
);

    logic                       v1_reg, v2_reg, v3_reg;
    logic                       v1_next, v2_next, v3_next;
    logic [rpb_pkg::MODE_W-1:0] mode_reg, mode1_reg, mode2_reg;
    logic                       en1, en2, en3;

    // A stage takes new data when it is empty or its content moves on.
    assign en3 = !v3_reg || !out_stall;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign v1_next = en1 ? in_valid : v1_reg;
    assign v2_next = en2 ? v1_reg   : v2_reg;
    assign v3_next = en3 ? v2_reg   : v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            mode_reg  <= rpb_pkg::MODE_BLACK;
            mode1_reg <= rpb_pkg::MODE_BLACK;
            mode2_reg <= rpb_pkg::MODE_BLACK;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            if (cfg_valid)
            begin
                mode_reg <= cfg_data;
            end
            if (en1 && in_valid)
            begin
                mode1_reg <= mode_reg;
            end
            if (en2 && v1_reg)
            begin
                mode2_reg <= mode1_reg;
            end
        end
    end

    always_comb
    begin
        ctrl.load1     = en1 && in_valid;
        ctrl.load2     = en2 && v1_reg;
        ctrl.load3     = en3 && v2_reg;
        ctrl.valid2    = v2_reg;
        ctrl.mode2     = mode2_reg;
        ctrl.in_stall  = !en1;
        ctrl.out_valid = v3_reg;
    end

endmodule

FILE: rtl/core/rpb_chan_dp.sv
// Three-stage datapath for one 8-bit color channel.
module rpb_chan_dp
(
    input  logic                       clk,
    input  rpb_pkg::ctrl_t             ctrl,
    input  logic [rpb_pkg::CHAN_W-1:0] base_chan,
    input  logic [rpb_pkg::CHAN_W-1:0] new_chan,
    input  logic [rpb_pkg::CHAN_W-1:0] alpha,
    output logic [rpb_pkg::CHAN_W-1:0] result_chan
);

    // Stage 1: the 8x8 products.
    logic [7:0]  b1_reg, a1_reg;
    logic [15:0] na1_reg, nb1_reg, ba1_reg;

    // Stage 2: per-mode values before clamping, and the dodge product.
    logic [7:0]  b2_reg, lerp2_reg, mul2_reg;
    logic [8:0]  add2_reg, sub2_reg;
    logic [10:0] scr2_reg;
    logic [23:0] nba2_reg;

    logic [7:0]  res_reg;

    logic [15:0] lerp_sum;
    logic [8:0]  add_next, sub_next;
    logic [10:0] scr_next;
    logic [8:0]  dodge_sum;
    logic [7:0]  res_next;

    always_ff @(posedge clk)
    begin
        if (ctrl.load1)
        begin
            b1_reg  <= base_chan;
            a1_reg  <= alpha;
            na1_reg <= {8'd0, new_chan} * {8'd0, alpha};
            nb1_reg <= {8'd0, new_chan} * {8'd0, base_chan};
            ba1_reg <= {8'd0, base_chan} * {8'd0, alpha};
        end
    end

    // Lerp as (b*256 + n*a - b*a) >> 8, never negative and below 256*256.
    assign lerp_sum = {b1_reg, 8'd0} + na1_reg - ba1_reg;
    assign add_next = {1'b0, b1_reg} + {1'b0, na1_reg[15:8]};
    assign sub_next = {1'b0, b1_reg} - {1'b0, na1_reg[15:8]};
    // (2*b*a) >> 8 equals (b*a) >> 7.
    assign scr_next = {3'd0, b1_reg} + {3'd0, a1_reg} - {2'd0, ba1_reg[15:7]};

    always_ff @(posedge clk)
    begin
        if (ctrl.load2)
        begin
            b2_reg    <= b1_reg;
            lerp2_reg <= lerp_sum[15:8];
            mul2_reg  <= nb1_reg[15:8];
            add2_reg  <= add_next;
            sub2_reg  <= sub_next;
            scr2_reg  <= scr_next;
            nba2_reg  <= {8'd0, nb1_reg} * {16'd0, a1_reg};
        end
    end

    assign dodge_sum = {1'b0, b2_reg} + {1'b0, nba2_reg[23:16]};

    always_comb
    begin
        unique case (ctrl.mode2)
            rpb_pkg::MODE_LERP:
            begin
                res_next = lerp2_reg;
            end
            rpb_pkg::MODE_ADD:
            begin
                res_next = add2_reg[8] ? rpb_pkg::CHAN_MAX : add2_reg[7:0];
            end
            rpb_pkg::MODE_SUBTRACT:
            begin
                res_next = sub2_reg[8] ? 8'd0 : sub2_reg[7:0];
            end
            rpb_pkg::MODE_MULTIPLY:
            begin
                res_next = mul2_reg;
            end
            rpb_pkg::MODE_DODGE:
            begin
                res_next = dodge_sum[8] ? rpb_pkg::CHAN_MAX : dodge_sum[7:0];
            end
            rpb_pkg::MODE_SCREEN:
            begin
                if (scr2_reg[10])
                begin
                    res_next = 8'd0;
                end
                else if (scr2_reg[9:8] != 2'd0)
                begin
                    res_next = rpb_pkg::CHAN_MAX;
                end
                else
                begin
                    res_next = scr2_reg[7:0];
                end
            end
            default:
            begin
                res_next = 8'd0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load3)
        begin
            res_reg <= res_next;
        end
    end

    assign result_chan = res_reg;

endmodule

FILE: rtl/core/rgb_pixel_blend_unit.sv
// Top level of the RGB pixel blend unit: control, three channel lanes, assertions.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------
//  input    | in_valid / in_stall    | base_rgb[23:0] new_rgb[23:0] alpha[7:0]
//  output   | out_valid / out_stall  | result_rgb[23:0]
//  config   | cfg_valid / cfg_ready  | cfg_data[2:0] (blend_mode)
//
// One pixel enters per clock while in_stall is low; out_valid rises once the pixel
// has passed the three stages: the product stage, the dodge product and per-mode
// sum stage, and the clamp/select output register.
// Reset clears the valid bits and sets blend_mode to black (0).
// Each stage moves on when it is empty or the stage after it moves, so a
// stall at the output fills bubbles first and loses or repeats nothing; the
// input stalls only when all three stages hold a transaction and out_stall is high.
module rgb_pixel_blend_unit
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [rpb_pkg::PIXEL_W-1:0] base_rgb,
    input  logic [rpb_pkg::PIXEL_W-1:0] new_rgb,
    input  logic [rpb_pkg::CHAN_W-1:0]  alpha,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [rpb_pkg::PIXEL_W-1:0] result_rgb,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [rpb_pkg::MODE_W-1:0]  cfg_data
);

    rpb_pkg::ctrl_t ctrl;

    // The mode register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    rpb_pipe_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .ctrl      (ctrl)
    );

    assign in_stall  = ctrl.in_stall;
    assign out_valid = ctrl.out_valid;

    // One lane per color channel; all lanes share the same control.
    for (genvar ch = 0; ch < 3; ch++)
    begin : g_chan
        rpb_chan_dp u_chan
        (
            .clk         (clk),
            .ctrl        (ctrl),
            .base_chan   (base_rgb[ch*rpb_pkg::CHAN_W +: rpb_pkg::CHAN_W]),
            .new_chan    (new_rgb[ch*rpb_pkg::CHAN_W +: rpb_pkg::CHAN_W]),
            .alpha       (alpha),
            .result_chan (result_rgb[ch*rpb_pkg::CHAN_W +: rpb_pkg::CHAN_W])
        );
    end

`ifndef NO_ASSERTIONS
    // Input stalls only when the whole pipe is full and the output is held.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while pipeline had room");

    // A held output register must not be overwritten.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> !ctrl.load3)
        else $error("output register loaded during stall");

    // Black mode drives a zero pixel into the output register.
    a_black_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.load3 && ctrl.valid2 &&
         (ctrl.mode2 == rpb_pkg::MODE_BLACK || ctrl.mode2 == rpb_pkg::MODE_SPARE))
        |=> (result_rgb == '0))
        else $error("black mode produced nonzero pixel");
`endif

endmodule
